// ===== design/lzsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lzsd_pkg;

  localparam int unsigned WINDOW_BYTES   = 4096;
  localparam int unsigned CMD_FIFO_DEPTH = 4;

  // token format
  localparam int unsigned DIST_W    = 12;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned SIZE_W    = 24;
  localparam logic [4:0]  LEN_BIAS  = 5'd3;
  localparam logic [3:0]  FLAG_BITS = 4'd8;
  localparam logic [3:0]  NIBBLE    = 4'hF;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIZE0,
    PH_SIZE1,
    PH_SIZE2,
    PH_FLAGS,
    PH_TOKEN,
    PH_REFLO,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_LIT,
    CMD_COPY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [7:0]          data;
    logic [DIST_W-1:0]   dist_m1;
    logic [COUNT_W-1:0]  count;
    logic                done;
  } cmd_t;

endpackage
`default_nettype wire

// ===== design/lzsd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lzsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = lzsd_pkg::WINDOW_BYTES
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== design/lzsd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lzsd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = lzsd_pkg::CMD_FIFO_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/lzsd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lzsd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          stream_first_i,
  input  wire logic          full_i,
  output logic               push_o,
  output lzsd_pkg::cmd_t     cmd_o
);

  localparam int unsigned SW = lzsd_pkg::SIZE_W;
  localparam int unsigned CW = lzsd_pkg::COUNT_W;

  lzsd_pkg::phase_e phase_q, phase_d;
  logic [SW-1:0]    remain_q;
  logic [7:0]       flags_q;
  logic [3:0]       left_q;
  logic [7:0]       held_q;

  logic          acc;
  logic [CW-1:0] len;
  logic [CW-1:0] copy_cnt;
  logic [SW-1:0] lit_rem, copy_rem, size_full;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && !full_i;

  assign len       = {1'b0, held_q[7:4]} + lzsd_pkg::LEN_BIAS;
  assign copy_cnt  = (remain_q < SW'(len)) ? remain_q[CW-1:0] : len;
  assign lit_rem   = remain_q - SW'(1);
  assign copy_rem  = remain_q - SW'(copy_cnt);
  assign size_full = {in_byte_i, remain_q[15:0]};

  // next state
  always_comb begin
    phase_d = phase_q;
    if (acc) begin
      if (stream_first_i) begin
        phase_d = lzsd_pkg::PH_SIZE0;
      end else begin
        case (phase_q)
          lzsd_pkg::PH_SIZE0: phase_d = lzsd_pkg::PH_SIZE1;
          lzsd_pkg::PH_SIZE1: phase_d = lzsd_pkg::PH_SIZE2;
          lzsd_pkg::PH_SIZE2: begin
            phase_d = (size_full == '0) ? lzsd_pkg::PH_DONE : lzsd_pkg::PH_FLAGS;
          end
          lzsd_pkg::PH_FLAGS: phase_d = lzsd_pkg::PH_TOKEN;
          lzsd_pkg::PH_TOKEN: begin
            if (flags_q[7]) begin
              phase_d = lzsd_pkg::PH_REFLO;
            end else if (lit_rem == '0) begin
              phase_d = lzsd_pkg::PH_DONE;
            end else if (left_q == 4'd1) begin
              phase_d = lzsd_pkg::PH_FLAGS;
            end else begin
              phase_d = lzsd_pkg::PH_TOKEN;
            end
          end
          lzsd_pkg::PH_REFLO: begin
            if (copy_rem == '0) begin
              phase_d = lzsd_pkg::PH_DONE;
            end else if (left_q == '0) begin
              phase_d = lzsd_pkg::PH_FLAGS;
            end else begin
              phase_d = lzsd_pkg::PH_TOKEN;
            end
          end
          lzsd_pkg::PH_IDLE: phase_d = lzsd_pkg::PH_IDLE;
          lzsd_pkg::PH_DONE: phase_d = lzsd_pkg::PH_DONE;
          default:           phase_d = lzsd_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // commands to the back end
  always_comb begin
    push_o        = 1'b0;
    cmd_o.kind    = lzsd_pkg::CMD_LIT;
    cmd_o.data    = in_byte_i;
    cmd_o.dist_m1 = {held_q[3:0] & lzsd_pkg::NIBBLE, in_byte_i};
    cmd_o.count   = CW'(1);
    cmd_o.done    = 1'b0;
    if (acc) begin
      if (stream_first_i) begin
        push_o     = 1'b1;
        cmd_o.kind = lzsd_pkg::CMD_START;
      end else begin
        case (phase_q)
          lzsd_pkg::PH_TOKEN: begin
            if (!flags_q[7]) begin
              push_o     = 1'b1;
              cmd_o.kind = lzsd_pkg::CMD_LIT;
              cmd_o.done = (lit_rem == '0);
            end
          end
          lzsd_pkg::PH_REFLO: begin
            push_o      = 1'b1;
            cmd_o.kind  = lzsd_pkg::CMD_COPY;
            cmd_o.count = copy_cnt;
            cmd_o.done  = (copy_rem == '0);
          end
          default: push_o = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= lzsd_pkg::PH_IDLE;
      remain_q <= '0;
      flags_q  <= '0;
      left_q   <= '0;
      held_q   <= '0;
    end else begin
      phase_q <= phase_d;
      if (acc) begin
        if (stream_first_i) begin
          remain_q <= '0;
          flags_q  <= '0;
          left_q   <= '0;
          held_q   <= '0;
        end else begin
          case (phase_q)
            lzsd_pkg::PH_SIZE0: remain_q <= SW'(in_byte_i);
            lzsd_pkg::PH_SIZE1: remain_q[15:8] <= in_byte_i;
            lzsd_pkg::PH_SIZE2: remain_q[23:16] <= in_byte_i;
            lzsd_pkg::PH_FLAGS: begin
              flags_q <= in_byte_i;
              left_q  <= lzsd_pkg::FLAG_BITS;
            end
            lzsd_pkg::PH_TOKEN: begin
              flags_q <= {flags_q[6:0], 1'b0};
              left_q  <= left_q - 4'd1;
              if (flags_q[7]) begin
                held_q <= in_byte_i;
              end else begin
                remain_q <= lit_rem;
              end
            end
            lzsd_pkg::PH_REFLO: remain_q <= copy_rem;
            default: remain_q <= remain_q;
          endcase
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/lzsd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lzsd_back #(
  parameter int unsigned WINDOW_BYTES = lzsd_pkg::WINDOW_BYTES
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lzsd_pkg::cmd_t   cmd_i,
  input  wire logic             cmd_valid_i,
  output logic                  cmd_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [7:0]       out_byte_o,
  output logic                  run_last_o,
  output logic                  stream_done_o,
  output logic                  bad_distance_o
);

  localparam int unsigned AW = $clog2(WINDOW_BYTES);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned CW = lzsd_pkg::COUNT_W;
  localparam int unsigned DW = lzsd_pkg::DIST_W;

  // current command
  logic           act_q;
  lzsd_pkg::cmd_t cmd_q;
  logic [CW-1:0]  cnt_q;
  logic [AW-1:0]  wp_q;
  logic [PW-1:0]  prod_q;    // bytes produced, saturating at the window size

  // output stage
  logic          b_valid_q;
  logic [AW-1:0] b_addr_q;
  logic          b_lit_q, b_last_q, b_bad_q, b_run_last_q, b_done_q;
  logic [7:0]    b_data_q;
  logic [7:0]    last_q;     // most recently written history byte

  logic          issue, last_issue, pop, out_acc;
  logic [PW-1:0] ref_dist;
  logic          bad;
  logic [AW-1:0] src;
  logic [7:0]    rdata;

  assign issue      = act_q && (!b_valid_q || out_ready_i);
  assign last_issue = issue && (cnt_q == CW'(1));
  assign pop        = cmd_valid_i && (!act_q || last_issue);
  assign cmd_pop_o  = pop;
  assign out_acc    = b_valid_q && out_ready_i;

  assign ref_dist = PW'(cmd_q.dist_m1) + PW'(1);
  assign bad      = (ref_dist > prod_q);
  assign src      = wp_q - AW'(cmd_q.dist_m1) - AW'(1);

  always_comb begin
    if (b_bad_q) begin
      out_byte_o = 8'h00;
    end else if (b_lit_q) begin
      out_byte_o = b_data_q;
    end else if (b_last_q) begin
      out_byte_o = last_q;   // distance one reads the byte written just before
    end else begin
      out_byte_o = rdata;
    end
  end

  assign out_valid_o    = b_valid_q;
  assign run_last_o     = b_run_last_q;
  assign stream_done_o  = b_done_q;
  assign bad_distance_o = b_bad_q;

  lzsd_ram #(
    .Width (8),
    .Depth (WINDOW_BYTES)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (out_acc),
    .waddr_i (b_addr_q),
    .wdata_i (out_byte_o),
    .re_i    (issue),
    .raddr_i (src),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      cnt_q     <= '0;
      wp_q      <= '0;
      prod_q    <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        wp_q   <= wp_q + AW'(1);
        cnt_q  <= cnt_q - CW'(1);
        if (prod_q != PW'(WINDOW_BYTES)) begin
          prod_q <= prod_q + PW'(1);
        end
        if (last_issue) begin
          act_q <= 1'b0;
        end
      end
      if (pop) begin
        cnt_q <= cmd_i.count;
        act_q <= (cmd_i.kind != lzsd_pkg::CMD_START);
        if (cmd_i.kind == lzsd_pkg::CMD_START) begin
          wp_q   <= '0;
          prod_q <= '0;
        end
      end
      if (issue) begin
        b_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q <= cmd_i;
    end
    if (issue) begin
      b_addr_q     <= wp_q;
      b_lit_q      <= (cmd_q.kind == lzsd_pkg::CMD_LIT);
      b_last_q     <= (cmd_q.dist_m1 == DW'(0));
      b_bad_q      <= (cmd_q.kind == lzsd_pkg::CMD_COPY) && bad;
      b_data_q     <= cmd_q.data;
      b_run_last_q <= (cnt_q == CW'(1));
      b_done_q     <= cmd_q.done && (cnt_q == CW'(1));
    end
    if (out_acc) begin
      last_q <= out_byte_o;
    end
  end

endmodule
`default_nettype wire

// ===== design/lz77_stream_decompressor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// streaming lz77 decoder for the classic type 0x10 format: one compressed byte per input
// beat, one decoded byte per output beat. a beat with stream_first_i set restarts the
// decoder; the next three beats give the 24-bit output size, low byte first, then flag
// bytes (msb first) select literals or two-byte references (length 3..18, distance
// 1..4096). header and flag beats, and the first byte of a reference, give no output.
// the front end parses input beats and is ready whenever its four-entry command queue has
// room, so input is taken one beat per cycle until the back end falls behind. the back
// end drains the queue at one output byte per cycle while out_ready_i is high, limited by
// the single read port of the 4096-byte history ram: a literal yields one byte, a reference
// up to 18 bytes (up to 9 output bytes per input beat on average). output stops
// exactly at the declared size and later beats are dropped until the next stream start.
// a copied byte reaching before the stream start comes out as zero with bad_distance_o.
// the history ram is not cleared after reset; no read of an unwritten entry ever reaches
// the output, so the block is ready right after reset.
module lz77_stream_decompressor #(
  parameter int unsigned WINDOW_BYTES = lzsd_pkg::WINDOW_BYTES
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       stream_first_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [7:0] out_byte_o,
  output logic            run_last_o,
  output logic            stream_done_o,
  output logic            bad_distance_o
);

  localparam int unsigned CmdW = $bits(lzsd_pkg::cmd_t);

  lzsd_pkg::cmd_t push_cmd, head_cmd;
  logic           push, pop, full, empty;
  logic [CmdW-1:0] head_raw;

  // parser: the start beat and token bytes become queue commands; header and flag bytes are consumed
  lzsd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .stream_first_i (stream_first_i),
    .full_i         (full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  // short queue so each side stalls on its own
  lzsd_fifo #(
    .Width (CmdW),
    .Depth (lzsd_pkg::CMD_FIFO_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_raw),
    .full_o  (full),
    .empty_o (empty)
  );

  assign head_cmd = lzsd_pkg::cmd_t'(head_raw);

  // executor: literals and window copies, one byte per cycle while the output is ready
  lzsd_back #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (head_cmd),
    .cmd_valid_i    (!empty),
    .cmd_pop_o      (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .run_last_o     (run_last_o),
    .stream_done_o  (stream_done_o),
    .bad_distance_o (bad_distance_o)
  );

  // the front end never pushes into a full queue
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full))
    else $error("command queue overflow");

  // a bad distance always yields a zero byte
  a_bad_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_distance_o) |-> (out_byte_o == 8'h00))
    else $error("bad distance with nonzero byte");

  // the byte that completes the stream closes its run
  a_done_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stream_done_o) |-> run_last_o)
    else $error("stream done without run last");

  // nothing is popped from an empty queue
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && empty))
    else $error("command queue underflow");

endmodule
`default_nettype wire
